[rtl/wsd_pkg.sv]
// Package for the WebSocket client deframer: result kinds, error codes,
// opcodes, parse phases and the result struct. No dependencies.
package wsd_pkg;

    localparam int MAX_W = 25;

    localparam logic [MAX_W-1:0] MAX_MSG_RESET = 25'(16 * 1024 * 1024);

    // result kinds
    localparam logic [2:0] KIND_DATA      = 3'd0;
    localparam logic [2:0] KIND_EMPTY_END = 3'd1;
    localparam logic [2:0] KIND_PING      = 3'd2;
    localparam logic [2:0] KIND_PING_END  = 3'd3;
    localparam logic [2:0] KIND_CLOSE     = 3'd4;
    localparam logic [2:0] KIND_ERROR     = 3'd5;

    // error codes
    localparam logic [2:0] ERR_MASKED     = 3'd0;
    localparam logic [2:0] ERR_FRAME_LONG = 3'd1;
    localparam logic [2:0] ERR_MSG_LONG   = 3'd2;
    localparam logic [2:0] ERR_NEW_OPEN   = 3'd3;
    localparam logic [2:0] ERR_ORPHAN     = 3'd4;
    localparam logic [2:0] ERR_OPCODE     = 3'd5;
    localparam logic [2:0] ERR_LINK_LOST  = 3'd6;

    // opcodes
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // 7-bit length escapes
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;

    typedef enum logic [1:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_PAYLOAD
    } phase_t;

    typedef struct packed {
        logic       vld;
        logic [2:0] kind;
        logic [7:0] payload_byte;
        logic       message_type;
        logic       last;
        logic [2:0] error_code;
    } res_t;

endpackage

[rtl/wsd_frame_parser.sv]
// Frame header parser and session state for the deframer.
// Depends on wsd_pkg. One byte per enabled cycle, result comes out combinationally.
module wsd_frame_parser
    import wsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  logic [7:0]       rx_byte,
    input  logic             link_lost,
    input  logic [MAX_W-1:0] max_bytes,
    output res_t             res
);

    phase_t            phase_reg, phase_next;
    logic              closed_reg, closed_next;
    logic [3:0]        ext_cnt_reg, ext_cnt_next;
    logic              fin_reg, fin_next;
    logic [3:0]        opcode_reg, opcode_next;
    logic [63:0]       rem_reg, rem_next;
    logic              doomed_reg, doomed_next;
    logic [2:0]        dcode_reg, dcode_next;
    logic              open_reg, open_next;
    logic              type_reg, type_next;
    logic [MAX_W-1:0]  len_reg, len_next;

    logic              fire;
    logic              masked;
    logic              is_ext;
    logic              hdr_now;
    logic [63:0]       hdr_len;
    logic [MAX_W-1:0]  pay;
    logic [MAX_W:0]    len_sum;
    logic              too_long;
    logic              hdr_zero;
    logic              data_op;
    logic              ctl_known;
    logic              d3, d4, d2, d5;
    logic              doom_new;
    logic [2:0]        dcode_new;
    logic              type_hdr;
    logic              final_b;
    logic              clear_msg;

    assign fire     = step_en && !closed_reg && !link_lost;
    assign masked   = rx_byte[7];
    assign is_ext   = (rx_byte[6:0] == LEN_EXT16) || (rx_byte[6:0] == LEN_EXT64);

    assign hdr_now  = (phase_reg == PH_HDR1 && !masked && !is_ext)
                   || (phase_reg == PH_EXT && ext_cnt_reg == 4'd1);
    assign hdr_len  = (phase_reg == PH_HDR1) ? {57'd0, rx_byte[6:0]}
                                             : {rem_reg[55:0], rx_byte};
    assign pay      = hdr_len[MAX_W-1:0];
    assign too_long = (hdr_len[63:MAX_W] != '0) || (pay > max_bytes);
    assign hdr_zero = (hdr_len == 64'd0);
    assign len_sum  = {1'b0, len_reg} + {1'b0, pay};

    assign data_op   = (opcode_reg == OP_CONT) || (opcode_reg == OP_TEXT)
                    || (opcode_reg == OP_BINARY);
    assign ctl_known = (opcode_reg == OP_CLOSE) || (opcode_reg == OP_PING)
                    || (opcode_reg == OP_PONG);

    // deferred checks, decided at header end
    assign d3 = data_op && (opcode_reg != OP_CONT) && open_reg;
    assign d4 = (opcode_reg == OP_CONT) && !open_reg;
    assign d2 = data_op && !d3 && !d4 && !hdr_zero
             && ((len_reg > max_bytes) || (len_sum > {1'b0, max_bytes}));
    assign d5 = !data_op && !ctl_known;
    assign doom_new  = d3 || d4 || d2 || d5;
    assign dcode_new = d3 ? ERR_NEW_OPEN
                     : d4 ? ERR_ORPHAN
                     : d2 ? ERR_MSG_LONG
                     : ERR_OPCODE;

    assign type_hdr = (opcode_reg != OP_CONT) ? (opcode_reg == OP_BINARY) : type_reg;
    assign final_b  = (rem_reg == 64'd1);

    // result
    always_comb
    begin
        res = '0;
        if (step_en && !closed_reg)
        begin
            if (link_lost)
            begin
                res.vld        = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_LINK_LOST;
            end
            else
            begin
                case (phase_reg)
                    PH_HDR1, PH_EXT:
                    begin
                        if (phase_reg == PH_HDR1 && masked)
                        begin
                            res.vld        = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_MASKED;
                        end
                        else if (hdr_now && too_long)
                        begin
                            res.vld        = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_FRAME_LONG;
                        end
                        else if (hdr_now && hdr_zero)
                        begin
                            if (doom_new)
                            begin
                                res.vld        = 1'b1;
                                res.kind       = KIND_ERROR;
                                res.error_code = dcode_new;
                            end
                            else if (data_op && fin_reg)
                            begin
                                res.vld          = 1'b1;
                                res.kind         = KIND_EMPTY_END;
                                res.message_type = type_hdr;
                                res.last         = 1'b1;
                            end
                            else if (opcode_reg == OP_CLOSE)
                            begin
                                res.vld  = 1'b1;
                                res.kind = KIND_CLOSE;
                            end
                            else if (opcode_reg == OP_PING)
                            begin
                                res.vld  = 1'b1;
                                res.kind = KIND_PING_END;
                                res.last = 1'b1;
                            end
                        end
                    end
                    PH_PAYLOAD:
                    begin
                        if (doomed_reg)
                        begin
                            if (final_b)
                            begin
                                res.vld        = 1'b1;
                                res.kind       = KIND_ERROR;
                                res.error_code = dcode_reg;
                            end
                        end
                        else if (data_op)
                        begin
                            res.vld          = 1'b1;
                            res.kind         = KIND_DATA;
                            res.payload_byte = rx_byte;
                            res.message_type = type_reg;
                            res.last         = final_b && fin_reg;
                        end
                        else if (opcode_reg == OP_PING)
                        begin
                            res.vld          = 1'b1;
                            res.kind         = KIND_PING;
                            res.payload_byte = rx_byte;
                            res.last         = final_b;
                        end
                        else if (opcode_reg == OP_CLOSE && final_b)
                        begin
                            res.vld  = 1'b1;
                            res.kind = KIND_CLOSE;
                        end
                    end
                    default:
                    begin
                        res = '0;
                    end
                endcase
            end
        end
    end

    // errors, close and message end all drop the open message
    assign clear_msg = res.vld && ((res.kind == KIND_ERROR) || (res.kind == KIND_CLOSE)
                    || (res.kind == KIND_EMPTY_END)
                    || (res.kind == KIND_DATA && res.last));

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step_en && !closed_reg)
        begin
            if (link_lost)
            begin
                phase_next = PH_HDR0;
            end
            else
            begin
                case (phase_reg)
                    PH_HDR0:
                    begin
                        phase_next = PH_HDR1;
                    end
                    PH_HDR1:
                    begin
                        // unmasked escape codes go on to the extended length; a masked byte ends the header
                        if (masked)
                            phase_next = PH_HDR0;
                        else if (is_ext)
                            phase_next = PH_EXT;
                        else if (too_long || hdr_zero)
                            phase_next = PH_HDR0;
                        else
                            phase_next = PH_PAYLOAD;
                    end
                    PH_EXT:
                    begin
                        if (hdr_now)
                            phase_next = (too_long || hdr_zero) ? PH_HDR0 : PH_PAYLOAD;
                    end
                    PH_PAYLOAD:
                    begin
                        if (final_b)
                            phase_next = PH_HDR0;
                    end
                    default:
                    begin
                        phase_next = PH_HDR0;
                    end
                endcase
            end
        end
    end

    // datapath state
    always_comb
    begin
        closed_next  = closed_reg;
        ext_cnt_next = ext_cnt_reg;
        fin_next     = fin_reg;
        opcode_next  = opcode_reg;
        rem_next     = rem_reg;
        doomed_next  = doomed_reg;
        dcode_next   = dcode_reg;
        open_next    = open_reg;
        type_next    = type_reg;
        len_next     = len_reg;

        if (fire)
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    fin_next    = rx_byte[7];
                    opcode_next = rx_byte[3:0];
                end
                PH_HDR1:
                begin
                    if (!masked)
                    begin
                        if (is_ext)
                        begin
                            rem_next     = 64'd0;
                            ext_cnt_next = (rx_byte[6:0] == LEN_EXT16) ? EXT16_BYTES
                                                                       : EXT64_BYTES;
                        end
                        else
                        begin
                            rem_next = hdr_len;
                        end
                    end
                end
                PH_EXT:
                begin
                    rem_next     = hdr_len;
                    ext_cnt_next = ext_cnt_reg - 4'd1;
                end
                PH_PAYLOAD:
                begin
                    rem_next = rem_reg - 64'd1;
                end
                default:
                begin
                    rem_next = rem_reg;
                end
            endcase

            if (hdr_now && !too_long)
            begin
                doomed_next = doom_new;
                dcode_next  = doom_new ? dcode_new : ERR_MASKED;
                if (data_op && !doom_new)
                begin
                    if (opcode_reg != OP_CONT)
                    begin
                        open_next = 1'b1;
                        type_next = (opcode_reg == OP_BINARY);
                        len_next  = pay;
                    end
                    else
                    begin
                        len_next = len_sum[MAX_W-1:0];
                    end
                end
            end
        end

        if (clear_msg)
        begin
            open_next = 1'b0;
            len_next  = '0;
            if (res.kind == KIND_ERROR || res.kind == KIND_CLOSE)
                closed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            closed_reg  <= 1'b0;
            ext_cnt_reg <= '0;
            fin_reg     <= 1'b0;
            opcode_reg  <= '0;
            rem_reg     <= '0;
            doomed_reg  <= 1'b0;
            dcode_reg   <= '0;
            open_reg    <= 1'b0;
            type_reg    <= 1'b0;
            len_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            closed_reg  <= closed_next;
            ext_cnt_reg <= ext_cnt_next;
            fin_reg     <= fin_next;
            opcode_reg  <= opcode_next;
            rem_reg     <= rem_next;
            doomed_reg  <= doomed_next;
            dcode_reg   <= dcode_next;
            open_reg    <= open_next;
            type_reg    <= type_next;
            len_reg     <= len_next;
        end
    end

endmodule

[rtl/wsd_out_reg.sv]
// Result register of the deframer, drives the output channel.
// Depends on wsd_pkg (res_t).
module wsd_out_reg
    import wsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  res_t       res,
    output logic       out_valid,
    output logic [2:0] kind,
    output logic [7:0] payload_byte,
    output logic       message_type,
    output logic       last,
    output logic [2:0] error_code
);

    logic vld_reg;
    res_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (load)
            vld_reg <= res.vld;
    end

    always_ff @(posedge clk)
    begin
        if (load && res.vld)
            data_reg <= res;
    end

    assign out_valid    = vld_reg;
    assign kind         = data_reg.kind;
    assign payload_byte = data_reg.payload_byte;
    assign message_type = data_reg.message_type;
    assign last         = data_reg.last;
    assign error_code   = data_reg.error_code;

endmodule

[rtl/websocket_client_deframer.sv]
// WebSocket client deframer, server-to-client direction (RFC 6455 framing).
// Path: an accepted request passes the input reg and then the result reg
// before its result can be taken. Throughput: one request per cycle when the
// output is not stalled; the per-byte parse is a single pass.
// Reset: rst_n async active low; parser returns to first header byte, session
// open, no message open, max_message_bytes = 16 MiB.
//
// Pipeline:
//   input register  -> holds one request (rx_byte, link_lost)
//   wsd_frame_parser -> header phases, length decode, deferred error checks,
//                       session/message state; advances once per request
//   wsd_out_reg     -> result register feeding the output channel
// The pipe advances whenever the result register is empty or being drained,
// so requests flow back to back. While a result waits, the input register
// still takes one request and then stalls the input.
// Requests that produce no result (header bytes, pong payload, swallowed
// payload of a doomed frame) simply leave the result register empty.
// Depends on wsd_pkg, wsd_frame_parser, wsd_out_reg.
module websocket_client_deframer
    import wsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             cfg_write_en,
    input  logic [MAX_W-1:0] cfg_write_data,

    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       rx_byte,
    input  logic             link_lost,

    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       kind,
    output logic [7:0]       payload_byte,
    output logic             message_type,
    output logic             last,
    output logic [2:0]       error_code
);

    logic             in_vld_reg;
    logic [7:0]       byte_reg;
    logic             lost_reg;
    logic [MAX_W-1:0] max_reg;
    logic             advance;
    res_t             res;

    // pipe moves when the result slot is free or draining this cycle
    assign advance  = !out_valid || !out_stall;
    assign in_stall = in_vld_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_reg <= MAX_MSG_RESET;
        else if (cfg_write_en)
            max_reg <= cfg_write_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            byte_reg <= rx_byte;
            lost_reg <= link_lost;
        end
    end

    wsd_frame_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (in_vld_reg && advance),
        .rx_byte   (byte_reg),
        .link_lost (lost_reg),
        .max_bytes (max_reg),
        .res       (res)
    );

    wsd_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .res          (res),
        .out_valid    (out_valid),
        .kind         (kind),
        .payload_byte (payload_byte),
        .message_type (message_type),
        .last         (last),
        .error_code   (error_code)
    );

endmodule
